/* hdl/tcw_pkg.sv */
`default_nettype none

package tcw_pkg;

    localparam int CELL_W = 16;
    localparam int POS_W  = 11;
    localparam int COLOR_W = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
    localparam logic [7:0] CHAR_BACKSPACE = 8'h08;
    localparam logic [7:0] CHAR_SPACE     = 8'h20;

    localparam logic [COLOR_W-1:0] RESET_FG = 4'h2;
    localparam logic [COLOR_W-1:0] RESET_BG = 4'h0;
    localparam logic [CELL_W-1:0] RESET_CELL = {RESET_BG, RESET_FG, CHAR_SPACE};

    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_LOCK  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FG_COLOR = 2'd0,
        CFG_BG_COLOR = 2'd1
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_EXEC,
        ST_SCROLL_RD,
        ST_SCROLL_WR,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [7:0]  char_code;
        logic [10:0] cell_index;
    } in_req_t;

    typedef struct packed {
        logic [POS_W-1:0]  cursor_position;
        logic [CELL_W-1:0] cell_value;
    } out_rsp_t;

endpackage

`default_nettype wire

/* hdl/tcw_screen_ram.sv */
`default_nettype none

module tcw_screen_ram
    import tcw_pkg::*;
#(
    parameter int DEPTH  = 2000,
    parameter int ADDR_W = 11
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [CELL_W-1:0] wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [CELL_W-1:0] rdata
);

    logic [CELL_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* hdl/text_console_writer_top.sv */
`default_nettype none

// Text console of ROWS x COLUMNS 16-bit cells (attribute high byte, character low byte)
// kept in a single-port-write, single-port-read screen memory. After reset the block
// first writes every cell with a blank in the reset colour, one cell per cycle, and only
// then takes the first request; configuration writes are accepted throughout. A put,
// lock, backspace, newline or read request passes through the execute and finish states
// after it is accepted; the result is loaded in the finish state, and the next request
// is taken only once the block is back in idle. A clear walks the memory once with a
// blank before its result. Leaving the bottom row scrolls through the memory port, one
// read and one write per moved cell, then blanks the bottom row. A result that waits
// for the receiver holds off the next request.
// Every request produces one result holding the linear cursor position.
module text_console_writer_top
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire in_req_t              in_data,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output out_rsp_t                  out_data,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [COLOR_W-1:0]   cfg_data
);

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int LIN_W  = $clog2(CELLS + 1);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLUMNS);

    state_t            state_reg, state_next;
    in_req_t           req_reg, req_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [LIN_W-1:0]  lin_reg, lin_next;
    logic [LIN_W-1:0]  guard_reg, guard_next;
    logic [ADDR_W-1:0] ptr_reg, ptr_next;
    logic [CELL_W-1:0] sweep_val_reg, sweep_val_next;
    logic              sweep_init_reg, sweep_init_next;
    logic              hit_reg, hit_next;
    logic              out_valid_reg, out_valid_next;
    out_rsp_t          out_data_reg, out_data_next;
    logic [COLOR_W-1:0] fg_reg, bg_reg;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [CELL_W-1:0] ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [CELL_W-1:0] ram_rdata;

    logic [CELL_W-1:0] blank_cell;
    logic [LIN_W-1:0]  lin_minus_one;
    logic [LIN_W-1:0]  newline_lin;

    assign blank_cell    = {bg_reg, fg_reg, CHAR_SPACE};
    assign lin_minus_one = lin_reg - LIN_W'(1);
    assign newline_lin   = lin_reg - LIN_W'(col_reg) + LIN_W'(COLUMNS);

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign cfg_ready = 1'b1;

    tcw_screen_ram #(
        .DEPTH (CELLS),
        .ADDR_W(ADDR_W)
    ) u_screen_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fg_reg <= RESET_FG;
            bg_reg <= RESET_BG;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_FG_COLOR: fg_reg <= cfg_data;
                CFG_BG_COLOR: bg_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_SWEEP;
            row_reg        <= '0;
            col_reg        <= '0;
            lin_reg        <= '0;
            guard_reg      <= '0;
            ptr_reg        <= '0;
            sweep_val_reg  <= RESET_CELL;
            sweep_init_reg <= 1'b1;
            hit_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            row_reg        <= row_next;
            col_reg        <= col_next;
            lin_reg        <= lin_next;
            guard_reg      <= guard_next;
            ptr_reg        <= ptr_next;
            sweep_val_reg  <= sweep_val_next;
            sweep_init_reg <= sweep_init_next;
            hit_reg        <= hit_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        out_data_reg <= out_data_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        req_next        = req_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        lin_next        = lin_reg;
        guard_next      = guard_reg;
        ptr_next        = ptr_reg;
        sweep_val_next  = sweep_val_reg;
        sweep_init_next = sweep_init_reg;
        hit_next        = hit_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        ram_we          = 1'b0;
        ram_waddr       = ptr_reg;
        ram_wdata       = sweep_val_reg;
        ram_re          = 1'b0;
        ram_raddr       = ptr_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_SWEEP:
            begin
                ram_we = 1'b1;
                ptr_next = ptr_reg + ADDR_W'(1);
                if (ptr_reg == ADDR_W'(CELLS - 1))
                begin
                    state_next = sweep_init_reg ? ST_IDLE : ST_FINISH;
                    sweep_init_next = 1'b0;
                end
            end

            ST_IDLE:
            begin
                if (in_valid)
                begin
                    req_next   = in_data;
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                state_next = ST_FINISH;
                hit_next   = 1'b0;
                case (op_t'(req_reg.operation))
                    OP_PUT:
                    begin
                        if (req_reg.char_code == CHAR_NEWLINE)
                        begin
                            guard_next = newline_lin;
                            col_next   = '0;
                            if (row_reg == ROW_W'(ROWS - 1))
                            begin
                                state_next = ST_SCROLL_RD;
                            end
                            else
                            begin
                                row_next = row_reg + ROW_W'(1);
                                lin_next = newline_lin;
                            end
                        end
                        else if (req_reg.char_code == CHAR_BACKSPACE)
                        begin
                            if (lin_reg != '0 && lin_minus_one >= guard_reg)
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = lin_minus_one[ADDR_W-1:0];
                                ram_wdata = blank_cell;
                                lin_next  = lin_minus_one;
                                if (col_reg == '0)
                                begin
                                    col_next = COL_W'(COLUMNS - 1);
                                    row_next = row_reg - ROW_W'(1);
                                end
                                else
                                begin
                                    col_next = col_reg - COL_W'(1);
                                end
                            end
                        end
                        else
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = lin_reg[ADDR_W-1:0];
                            ram_wdata = {bg_reg, fg_reg, req_reg.char_code};
                            if (col_reg == COL_W'(COLUMNS - 1))
                            begin
                                col_next = '0;
                                if (row_reg == ROW_W'(ROWS - 1))
                                begin
                                    state_next = ST_SCROLL_RD;
                                end
                                else
                                begin
                                    row_next = row_reg + ROW_W'(1);
                                    lin_next = lin_reg + LIN_W'(1);
                                end
                            end
                            else
                            begin
                                col_next = col_reg + COL_W'(1);
                                lin_next = lin_reg + LIN_W'(1);
                            end
                        end
                        if (state_next == ST_SCROLL_RD)
                        begin
                            row_next = ROW_W'(ROWS - 1);
                            col_next = '0;
                            lin_next = LIN_W'((ROWS - 1) * COLUMNS);
                            ptr_next = ADDR_W'(COLUMNS);
                        end
                    end

                    OP_LOCK:
                    begin
                        guard_next = lin_reg;
                    end

                    OP_CLEAR:
                    begin
                        row_next       = '0;
                        col_next       = '0;
                        lin_next       = '0;
                        ptr_next       = '0;
                        sweep_val_next = blank_cell;
                        state_next     = ST_SWEEP;
                    end

                    default:
                    begin
                        if (32'(req_reg.cell_index) < 32'(CELLS))
                        begin
                            ram_re    = 1'b1;
                            ram_raddr = req_reg.cell_index[ADDR_W-1:0];
                            hit_next  = 1'b1;
                        end
                    end
                endcase
            end

            ST_SCROLL_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = ptr_reg;
                state_next = ST_SCROLL_WR;
            end

            ST_SCROLL_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = ptr_reg - ADDR_W'(COLUMNS);
                ram_wdata = ram_rdata;
                if (ptr_reg == ADDR_W'(CELLS - 1))
                begin
                    ptr_next       = ADDR_W'((ROWS - 1) * COLUMNS);
                    sweep_val_next = blank_cell;
                    state_next     = ST_SWEEP;
                end
                else
                begin
                    ptr_next   = ptr_reg + ADDR_W'(1);
                    state_next = ST_SCROLL_RD;
                end
            end

            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next.cursor_position = POS_W'(lin_reg);
                    out_data_next.cell_value =
                        (req_reg.operation == OP_READ && hit_reg) ? ram_rdata : '0;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire
